// ----- rtl/vcva_pkg.sv -----
// shared types, constants and codes for the voltage corner vote aggregator
package vcva_pkg;

  localparam int LEVELS = 32;
  localparam int RAILS  = 2;
  localparam int LVL_W  = $clog2(LEVELS);
  localparam int CNT_W  = $clog2(LEVELS + 1);

  typedef logic [LVL_W-1:0] lvl_idx_t;

  localparam logic KIND_VOTE = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_PARAM = 2'd1;
  localparam logic [1:0] ST_BAD_STATE = 2'd2;

  localparam logic [1:0] REG_LEVEL_COUNT = 2'd0;
  localparam logic [1:0] REG_RAIL_COUNT  = 2'd1;
  localparam logic [1:0] REG_RAIL0_ADDR  = 2'd2;
  localparam logic [1:0] REG_RAIL1_ADDR  = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [15:0] from_corner;
    logic [15:0] to_corner;
    logic [4:0]  level_index;
    logic [15:0] level_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        command_valid;
    logic [31:0] rail_address;
    logic [4:0]  rail_level;
    logic [15:0] applied_corner;
    logic        last;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LOAD,
    S_NEW_GO,
    S_NEW_WAIT,
    S_OLD_GO,
    S_OLD_WAIT,
    S_OLD_RD,
    S_OLD_CHK,
    S_INC_RD,
    S_INC_WR,
    S_DEC_RD,
    S_DEC_WR,
    S_PEAK_GO,
    S_PEAK_WAIT,
    S_PK_RD,
    S_PK_VAL,
    S_PKR_GO,
    S_PKR_WAIT,
    S_EMIT0,
    S_EMIT1,
    S_DONE_OK,
    S_ERR_PARAM,
    S_ERR_STATE
  } state_t;

  // request from the sequencer to the table scanner
  typedef struct packed {
    logic             start;
    logic             peak;
    logic [15:0]      key;
    logic [CNT_W-1:0] limit;
  } scan_req_t;

  // scanner status and result
  typedef struct packed {
    logic     busy;
    logic     done;
    logic     found;
    lvl_idx_t idx;
    lvl_idx_t addr;
  } scan_rsp_t;

endpackage

// ----- rtl/vcva_scan.sv -----
// table scanner: one compare unit walks the level table or the vote counts
module vcva_scan (
  input  logic                clk,
  input  logic                rst,
  input  vcva_pkg::scan_req_t req,
  input  logic [15:0]         tbl_data,
  input  logic [15:0]         cnt_data,
  output vcva_pkg::scan_rsp_t rsp
);

  logic                       busy;
  logic                       pend;
  logic                       found;
  logic [vcva_pkg::CNT_W-1:0] cnt;
  vcva_pkg::lvl_idx_t         pend_idx;
  vcva_pkg::lvl_idx_t         hit;
  logic                       issue;
  logic                       hit_now;
  logic                       take;

  assign issue   = busy && (cnt < req.limit);
  // search: first entry at or above the key; peak: last nonzero count
  assign hit_now = req.peak ? (cnt_data != 16'd0) : (tbl_data >= req.key);
  assign take    = busy && pend && hit_now && (req.peak || !found);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      pend  <= 1'b0;
      found <= 1'b0;
      cnt   <= '0;
    end else if (req.start) begin
      busy  <= 1'b1;
      pend  <= 1'b0;
      found <= 1'b0;
      cnt   <= '0;
    end else if (busy) begin
      pend <= issue;
      if (issue) begin
        cnt <= cnt + 1'b1;
      end
      if (!issue && !pend) begin
        busy <= 1'b0;
      end
      if (take) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_idx <= cnt[vcva_pkg::LVL_W-1:0];
    if (take) begin
      hit <= pend_idx;
    end
  end

  always_comb begin
    rsp.busy  = busy;
    rsp.done  = busy && !issue && !pend;
    rsp.found = found;
    rsp.idx   = hit;
    rsp.addr  = cnt[vcva_pkg::LVL_W-1:0];
  end

endmodule

// ----- rtl/voltage_corner_vote_aggregator.sv -----
// top level: vote sequencer, level table, vote counts and result register
//
//   channel   ports                                   transfer when
//   item      start, busy, item                       start && !busy
//   result    result_valid, result                    result_valid (one cycle, no stall)
//   config    cfg_write, cfg_index, cfg_data          cfg_write
//
// a vote item makes up to three walks of the level table and one of the counts, each over
// the active levels, through the one scanner compare unit, plus read-modify-write of the
// counts through the count memory port and the rail results.
// busy stays high from the transfer of an item until its last result is registered.
// reset clears the counts through valid bits, the voted corner and the control registers.
// results cannot be stalled; a vote gives one result or one per rail in consecutive cycles.
module voltage_corner_vote_aggregator (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  vcva_pkg::in_item_t  item,
  output logic                result_valid,
  output vcva_pkg::out_item_t result,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  vcva_pkg::state_t state, state_next;

  logic [5:0]  level_count;
  logic [1:0]  rail_count;
  logic [31:0] rail0_address;
  logic [31:0] rail1_address;

  vcva_pkg::in_item_t item_q;
  vcva_pkg::lvl_idx_t new_idx;
  vcva_pkg::lvl_idx_t old_idx;
  vcva_pkg::lvl_idx_t hl;
  logic [15:0]        peak;
  logic [15:0]        voted_corner;

  logic [vcva_pkg::CNT_W-1:0] nlev;
  logic [1:0]                 nrail;

  logic [15:0]        level_table [vcva_pkg::LEVELS];
  logic [15:0]        vote_counts [vcva_pkg::LEVELS];
  logic [vcva_pkg::LEVELS-1:0] cvalid;
  logic [15:0]        tbl_q;
  logic [15:0]        cmem_q;
  logic               cvld_q;
  logic [15:0]        cnt_data;

  logic               tbl_we;
  vcva_pkg::lvl_idx_t tbl_waddr;
  vcva_pkg::lvl_idx_t tbl_raddr;
  logic               cnt_we;
  vcva_pkg::lvl_idx_t cnt_addr;
  logic [15:0]        cnt_wdata;

  vcva_pkg::scan_req_t scan_req;
  vcva_pkg::scan_rsp_t scan_rsp;

  vcva_pkg::out_item_t res_next;
  logic                res_valid_next;
  logic [15:0]         peak_val;

  assign nlev = (32'(level_count) > 32'(vcva_pkg::LEVELS)) ?
                vcva_pkg::CNT_W'(vcva_pkg::LEVELS) : vcva_pkg::CNT_W'(level_count);
  assign nrail = (32'(rail_count) > 32'(vcva_pkg::RAILS)) ?
                 2'(vcva_pkg::RAILS) : rail_count;
  assign busy     = (state != vcva_pkg::S_IDLE);
  assign cnt_data = cvld_q ? cmem_q : 16'd0;
  assign peak_val = scan_rsp.found ? tbl_q : 16'd0;

  vcva_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .req      (scan_req),
    .tbl_data (tbl_q),
    .cnt_data (cnt_data),
    .rsp      (scan_rsp)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      level_count   <= 6'd1;
      rail_count    <= 2'd1;
      rail0_address <= 32'd0;
      rail1_address <= 32'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        vcva_pkg::REG_LEVEL_COUNT: level_count   <= cfg_data[5:0];
        vcva_pkg::REG_RAIL_COUNT:  rail_count    <= cfg_data[1:0];
        vcva_pkg::REG_RAIL0_ADDR:  rail0_address <= cfg_data;
        vcva_pkg::REG_RAIL1_ADDR:  rail1_address <= cfg_data;
        default: ;
      endcase
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      level_table[tbl_waddr] <= item_q.level_value;
    end
    tbl_q <= level_table[tbl_raddr];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      vote_counts[cnt_addr] <= cnt_wdata;
    end
    cmem_q <= vote_counts[cnt_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cvalid <= '0;
      cvld_q <= 1'b0;
    end else begin
      if (cnt_we) begin
        cvalid[cnt_addr] <= 1'b1;
      end
      cvld_q <= cvalid[cnt_addr];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      vcva_pkg::S_IDLE: begin
        if (start) begin
          if (item.kind == vcva_pkg::KIND_LOAD) begin
            state_next = vcva_pkg::S_LOAD;
          end else if (item.to_corner != 16'd0) begin
            state_next = vcva_pkg::S_NEW_GO;
          end else if (item.from_corner != 16'd0) begin
            state_next = vcva_pkg::S_OLD_GO;
          end else begin
            state_next = vcva_pkg::S_PEAK_GO;
          end
        end
      end
      vcva_pkg::S_LOAD:     state_next = vcva_pkg::S_IDLE;
      vcva_pkg::S_NEW_GO:   state_next = vcva_pkg::S_NEW_WAIT;
      vcva_pkg::S_NEW_WAIT: begin
        if (scan_rsp.done) begin
          if (!scan_rsp.found) begin
            state_next = vcva_pkg::S_ERR_PARAM;
          end else if (item_q.from_corner != 16'd0) begin
            state_next = vcva_pkg::S_OLD_GO;
          end else begin
            state_next = vcva_pkg::S_INC_RD;
          end
        end
      end
      vcva_pkg::S_OLD_GO:   state_next = vcva_pkg::S_OLD_WAIT;
      vcva_pkg::S_OLD_WAIT: begin
        if (scan_rsp.done) begin
          state_next = scan_rsp.found ? vcva_pkg::S_OLD_RD : vcva_pkg::S_ERR_PARAM;
        end
      end
      vcva_pkg::S_OLD_RD:   state_next = vcva_pkg::S_OLD_CHK;
      vcva_pkg::S_OLD_CHK: begin
        if (cnt_data == 16'd0) begin
          state_next = vcva_pkg::S_ERR_STATE;
        end else if (item_q.to_corner != 16'd0) begin
          state_next = vcva_pkg::S_INC_RD;
        end else begin
          state_next = vcva_pkg::S_DEC_RD;
        end
      end
      vcva_pkg::S_INC_RD:   state_next = vcva_pkg::S_INC_WR;
      vcva_pkg::S_INC_WR: begin
        state_next = (item_q.from_corner != 16'd0) ? vcva_pkg::S_DEC_RD : vcva_pkg::S_PEAK_GO;
      end
      vcva_pkg::S_DEC_RD:   state_next = vcva_pkg::S_DEC_WR;
      vcva_pkg::S_DEC_WR:   state_next = vcva_pkg::S_PEAK_GO;
      vcva_pkg::S_PEAK_GO:  state_next = vcva_pkg::S_PEAK_WAIT;
      vcva_pkg::S_PEAK_WAIT: begin
        if (scan_rsp.done) begin
          state_next = vcva_pkg::S_PK_RD;
        end
      end
      vcva_pkg::S_PK_RD:    state_next = vcva_pkg::S_PK_VAL;
      vcva_pkg::S_PK_VAL: begin
        state_next = (peak_val == voted_corner) ? vcva_pkg::S_DONE_OK : vcva_pkg::S_PKR_GO;
      end
      vcva_pkg::S_PKR_GO:   state_next = vcva_pkg::S_PKR_WAIT;
      vcva_pkg::S_PKR_WAIT: begin
        if (scan_rsp.done) begin
          if (!scan_rsp.found || nrail == 2'd0) begin
            state_next = vcva_pkg::S_DONE_OK;
          end else begin
            state_next = vcva_pkg::S_EMIT0;
          end
        end
      end
      vcva_pkg::S_EMIT0: begin
        state_next = (nrail == 2'd1) ? vcva_pkg::S_IDLE : vcva_pkg::S_EMIT1;
      end
      vcva_pkg::S_EMIT1:     state_next = vcva_pkg::S_IDLE;
      vcva_pkg::S_DONE_OK:   state_next = vcva_pkg::S_IDLE;
      vcva_pkg::S_ERR_PARAM: state_next = vcva_pkg::S_IDLE;
      vcva_pkg::S_ERR_STATE: state_next = vcva_pkg::S_IDLE;
      default:               state_next = vcva_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    scan_req.start = 1'b0;
    scan_req.peak  = 1'b0;
    scan_req.key   = 16'd0;
    scan_req.limit = nlev;
    tbl_we         = 1'b0;
    tbl_waddr      = vcva_pkg::LVL_W'(item_q.level_index);
    tbl_raddr      = scan_rsp.addr;
    cnt_we         = 1'b0;
    cnt_addr       = scan_rsp.addr;
    cnt_wdata      = cnt_data;
    res_valid_next = 1'b0;
    res_next.status         = vcva_pkg::ST_OK;
    res_next.command_valid  = 1'b0;
    res_next.rail_address   = 32'd0;
    res_next.rail_level     = 5'd0;
    res_next.applied_corner = voted_corner;
    res_next.last           = 1'b1;
    case (state)
      vcva_pkg::S_LOAD: begin
        tbl_we         = (32'(item_q.level_index) < 32'(vcva_pkg::LEVELS));
        res_valid_next = 1'b1;
      end
      vcva_pkg::S_NEW_GO, vcva_pkg::S_NEW_WAIT: begin
        scan_req.start = (state == vcva_pkg::S_NEW_GO);
        scan_req.key   = item_q.to_corner;
      end
      vcva_pkg::S_OLD_GO, vcva_pkg::S_OLD_WAIT: begin
        scan_req.start = (state == vcva_pkg::S_OLD_GO);
        scan_req.key   = item_q.from_corner;
      end
      vcva_pkg::S_OLD_RD, vcva_pkg::S_DEC_RD: begin
        cnt_addr = old_idx;
      end
      vcva_pkg::S_INC_RD: begin
        cnt_addr = new_idx;
      end
      vcva_pkg::S_INC_WR: begin
        cnt_addr  = new_idx;
        cnt_we    = 1'b1;
        cnt_wdata = cnt_data + 16'd1;
      end
      vcva_pkg::S_DEC_WR: begin
        cnt_addr  = old_idx;
        cnt_we    = 1'b1;
        cnt_wdata = cnt_data - 16'd1;
      end
      vcva_pkg::S_PEAK_GO, vcva_pkg::S_PEAK_WAIT: begin
        scan_req.start = (state == vcva_pkg::S_PEAK_GO);
        scan_req.peak  = 1'b1;
      end
      vcva_pkg::S_PK_RD: begin
        tbl_raddr = scan_rsp.idx;
      end
      vcva_pkg::S_PKR_GO, vcva_pkg::S_PKR_WAIT: begin
        scan_req.start = (state == vcva_pkg::S_PKR_GO);
        scan_req.key   = peak;
      end
      vcva_pkg::S_EMIT0: begin
        res_valid_next         = 1'b1;
        res_next.command_valid = 1'b1;
        res_next.rail_address  = rail0_address;
        res_next.rail_level    = 5'(hl);
        res_next.last          = (nrail == 2'd1);
      end
      vcva_pkg::S_EMIT1: begin
        res_valid_next         = 1'b1;
        res_next.command_valid = 1'b1;
        res_next.rail_address  = rail1_address;
        res_next.rail_level    = 5'(hl);
      end
      vcva_pkg::S_DONE_OK: begin
        res_valid_next = 1'b1;
      end
      vcva_pkg::S_ERR_PARAM: begin
        res_valid_next  = 1'b1;
        res_next.status = vcva_pkg::ST_BAD_PARAM;
      end
      vcva_pkg::S_ERR_STATE: begin
        res_valid_next  = 1'b1;
        res_next.status = vcva_pkg::ST_BAD_STATE;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= vcva_pkg::S_IDLE;
      result_valid <= 1'b0;
      voted_corner <= 16'd0;
    end else begin
      state        <= state_next;
      result_valid <= res_valid_next;
      if (state == vcva_pkg::S_PKR_WAIT && scan_rsp.done && scan_rsp.found) begin
        voted_corner <= peak;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    result <= res_next;
    if (state == vcva_pkg::S_IDLE && start) begin
      item_q <= item;
    end
    if (state == vcva_pkg::S_NEW_WAIT && scan_rsp.done) begin
      new_idx <= scan_rsp.idx;
    end
    if (state == vcva_pkg::S_OLD_WAIT && scan_rsp.done) begin
      old_idx <= scan_rsp.idx;
    end
    if (state == vcva_pkg::S_PK_VAL) begin
      peak <= peak_val;
    end
    if (state == vcva_pkg::S_PKR_WAIT && scan_rsp.done) begin
      hl <= scan_rsp.idx;
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_cmd_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.command_valid |-> result.status == vcva_pkg::ST_OK)
    else $error("rail command with error status");

  a_second_rail: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |=> result_valid && result.last)
    else $error("missing final rail command");

  a_scan_done: assert property (@(posedge clk) disable iff (rst)
    scan_rsp.done |-> (state == vcva_pkg::S_NEW_WAIT || state == vcva_pkg::S_OLD_WAIT ||
                       state == vcva_pkg::S_PEAK_WAIT || state == vcva_pkg::S_PKR_WAIT))
    else $error("scan finished outside a wait state");

  a_voted_change: assert property (@(posedge clk) disable iff (rst)
    voted_corner != $past(voted_corner) |-> $past(state) == vcva_pkg::S_PKR_WAIT)
    else $error("voted corner changed outside peak resolve");

endmodule
